### hw/rtl/zsbf_pkg.sv
// Shared types, constants and slot layout for the zlib stored-block framer.
package zsbf_pkg;

  localparam int LENGTH_BITS_DEFAULT = 32;
  localparam int CFG_BITS            = 32;
  localparam int SLOT_COUNT          = 12;

  localparam int SLOT_CMF        = 0;
  localparam int SLOT_FLG        = 1;
  localparam int SLOT_FINAL      = 2;
  localparam int SLOT_LEN_LO     = 3;
  localparam int SLOT_LEN_HI     = 4;
  localparam int SLOT_NLEN_LO    = 5;
  localparam int SLOT_NLEN_HI    = 6;
  localparam int SLOT_DATA       = 7;
  localparam int SLOT_HIGH_HI    = 8;
  localparam int SLOT_HIGH_LO    = 9;
  localparam int SLOT_LOW_HI     = 10;
  localparam int SLOT_LOW_LO     = 11;

  localparam logic [7:0]  ZLIB_CMF  = 8'h78;
  localparam logic [7:0]  ZLIB_FLG  = 8'h01;
  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [15:0] MAX_BLOCK = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_ZLIB_HDR  = 2'd0,
    KIND_BLOCK_HDR = 2'd1,
    KIND_DATA      = 2'd2,
    KIND_TRAILER   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [SLOT_COUNT-1:0]       mask;
    logic [SLOT_COUNT-1:0][7:0]  bytes;
  } frame_t;

  function automatic kind_t slot_kind(input int slot);
    kind_t k;
    case (slot) inside
      [SLOT_CMF:SLOT_FLG]:          k = KIND_ZLIB_HDR;
      [SLOT_FINAL:SLOT_NLEN_HI]:    k = KIND_BLOCK_HDR;
      SLOT_DATA:                    k = KIND_DATA;
      default:                      k = KIND_TRAILER;
    endcase
    return k;
  endfunction

endpackage

### hw/rtl/zsbf_core.sv
// Stream state, block sizing and Adler-32 update; builds the output frame of one byte.
module zsbf_core
  import zsbf_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  output frame_t              frame
);

  logic [LENGTH_BITS-1:0] stream_length;
  logic [LENGTH_BITS-1:0] bytes_done;
  logic [15:0]            block_left;
  logic [15:0]            sum_low;
  logic [15:0]            sum_high;

  logic [LENGTH_BITS-1:0] bytes_done_next;
  logic [15:0]            block_left_next;
  logic [15:0]            sum_low_next;
  logic [15:0]            sum_high_next;

  logic [LENGTH_BITS+CFG_BITS-1:0] cfg_ext;
  logic                   first;
  logic [15:0]            eff_low;
  logic [15:0]            eff_high;
  logic [15:0]            eff_left;
  logic [LENGTH_BITS-1:0] rem;
  logic                   last;
  logic                   opening;
  logic                   is_final;
  logic [15:0]            blk;
  logic [15:0]            nblk;
  logic [16:0]            low_sum;
  logic [16:0]            low_mod;
  logic [16:0]            high_sum;
  logic [16:0]            high_mod;

  assign cfg_ext = {{LENGTH_BITS{1'b0}}, cfg_data};

  always_comb begin
    first    = (bytes_done == '0);
    eff_low  = first ? 16'd1 : sum_low;
    eff_high = first ? 16'd0 : sum_high;
    eff_left = first ? 16'd0 : block_left;

    rem      = (stream_length > bytes_done) ? (stream_length - bytes_done)
                                            : LENGTH_BITS'(1);
    last     = (rem == LENGTH_BITS'(1));
    opening  = (eff_left == 16'd0);
    is_final = (rem <= LENGTH_BITS'(MAX_BLOCK));
    blk      = (rem < LENGTH_BITS'(MAX_BLOCK)) ? rem[15:0] : MAX_BLOCK;
    nblk     = ~blk;

    low_sum  = {1'b0, eff_low} + {9'd0, data_byte};
    low_mod  = (low_sum >= ADLER_MOD) ? (low_sum - ADLER_MOD) : low_sum;
    high_sum = {1'b0, eff_high} + low_mod;
    high_mod = (high_sum >= ADLER_MOD) ? (high_sum - ADLER_MOD) : high_sum;

    if (last) begin
      bytes_done_next = '0;
      block_left_next = 16'd0;
      sum_low_next    = 16'd1;
      sum_high_next   = 16'd0;
    end else begin
      bytes_done_next = bytes_done + LENGTH_BITS'(1);
      block_left_next = (opening ? blk : eff_left) - 16'd1;
      sum_low_next    = low_mod[15:0];
      sum_high_next   = high_mod[15:0];
    end
  end

  always_comb begin
    frame.mask                      = '0;
    frame.mask[SLOT_CMF]            = first;
    frame.mask[SLOT_FLG]            = first;
    frame.mask[SLOT_FINAL]          = opening;
    frame.mask[SLOT_LEN_LO]         = opening;
    frame.mask[SLOT_LEN_HI]         = opening;
    frame.mask[SLOT_NLEN_LO]        = opening;
    frame.mask[SLOT_NLEN_HI]        = opening;
    frame.mask[SLOT_DATA]           = 1'b1;
    frame.mask[SLOT_HIGH_HI]        = last;
    frame.mask[SLOT_HIGH_LO]        = last;
    frame.mask[SLOT_LOW_HI]         = last;
    frame.mask[SLOT_LOW_LO]         = last;

    frame.bytes[SLOT_CMF]     = ZLIB_CMF;
    frame.bytes[SLOT_FLG]     = ZLIB_FLG;
    frame.bytes[SLOT_FINAL]   = {7'd0, is_final};
    frame.bytes[SLOT_LEN_LO]  = blk[7:0];
    frame.bytes[SLOT_LEN_HI]  = blk[15:8];
    frame.bytes[SLOT_NLEN_LO] = nblk[7:0];
    frame.bytes[SLOT_NLEN_HI] = nblk[15:8];
    frame.bytes[SLOT_DATA]    = data_byte;
    frame.bytes[SLOT_HIGH_HI] = high_mod[15:8];
    frame.bytes[SLOT_HIGH_LO] = high_mod[7:0];
    frame.bytes[SLOT_LOW_HI]  = low_mod[15:8];
    frame.bytes[SLOT_LOW_LO]  = low_mod[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_length <= LENGTH_BITS'(1);
      bytes_done    <= '0;
      block_left    <= 16'd0;
      sum_low       <= 16'd1;
      sum_high      <= 16'd0;
    end else begin
      if (cfg_write) begin
        stream_length <= cfg_ext[LENGTH_BITS-1:0];
      end
      if (accept) begin
        bytes_done <= bytes_done_next;
        block_left <= block_left_next;
        sum_low    <= sum_low_next;
        sum_high   <= sum_high_next;
      end
    end
  end

endmodule

### hw/rtl/zsbf_serializer.sv
// Result register holding one frame and emitting its bytes one transfer at a time.
module zsbf_serializer
  import zsbf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  frame_t     frame,
  output logic       load_ok,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       last_of_run,
  output logic       end_of_stream
);

  logic [SLOT_COUNT-1:0]      mask;
  logic [SLOT_COUNT-1:0]      mask_next;
  logic [SLOT_COUNT-1:0][7:0] bytes;
  logic [SLOT_COUNT-1:0]      sel;
  logic [SLOT_COUNT-1:0]      rest;

  always_comb begin
    sel           = mask & (~mask + SLOT_COUNT'(1));
    rest          = mask & ~sel;
    out_valid     = (mask != '0);
    last_of_run   = (rest == '0);
    end_of_stream = sel[SLOT_LOW_LO];
    out_byte      = 8'd0;
    out_kind      = 2'd0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      out_byte = out_byte | (sel[i] ? bytes[i] : 8'd0);
      out_kind = out_kind | (sel[i] ? 2'(slot_kind(i)) : 2'd0);
    end
    load_ok = !out_valid || (out_ready && last_of_run);
  end

  always_comb begin
    mask_next = mask;
    if (load) begin
      mask_next = frame.mask;
    end else if (out_valid && out_ready) begin
      mask_next = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else begin
      mask <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= frame.bytes;
    end
  end

endmodule

### hw/rtl/zlib_stored_block_framer.sv
// Top level of the zlib stored-block framer.
// Frames a raw byte stream of cfg-set length as a zlib stream of stored deflate blocks
// with an Adler-32 trailer. Each accepted input byte produces one to twelve output
// transfers: the zlib header (2 bytes) before the first byte, a block header (5 bytes)
// when a block opens, the data byte, and the trailer (4 bytes) after the last byte. A
// new byte is accepted in the same cycle that the final transfer of the previous byte
// completes, so plain data bytes flow at one per cycle while m_axis_tready is high; a
// byte holds the one-byte-wide output port for its data, header and trailer bytes.
// Write stream_length only while no stream is in progress.
module zlib_stored_block_framer
  import zsbf_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_BITS-1:0] cfg_data,       // stream_length
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // data_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // out_byte
  output logic [2:0]          m_axis_tuser,   // out_kind[1:0], end_of_stream[2]
  output logic                m_axis_tlast    // last_of_run
);

  logic       accept;
  frame_t     frame;
  logic [1:0] out_kind;
  logic       end_of_stream;

  assign cfg_ready = 1'b1;
  assign accept    = s_axis_tvalid && s_axis_tready;

  zsbf_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .data_byte (s_axis_tdata),
    .frame     (frame)
  );

  zsbf_serializer u_ser (
    .clk           (clk),
    .rst           (rst),
    .load          (accept),
    .frame         (frame),
    .load_ok       (s_axis_tready),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_byte      (m_axis_tdata),
    .out_kind      (out_kind),
    .last_of_run   (m_axis_tlast),
    .end_of_stream (end_of_stream)
  );

  assign m_axis_tuser = {end_of_stream, out_kind};

endmodule

### hw/rtl/zsbf_checker.sv
// Port-level checks for the zlib stored-block framer, bound to the top level.
module zsbf_checker
  import zsbf_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [7:0]          m_axis_tdata,
  input logic [2:0]          m_axis_tuser,
  input logic                m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output transfer changed while stalled");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_accept_gives_output: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted byte produced no output");

  a_eos_is_last_trailer: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2] |->
      m_axis_tlast && (m_axis_tuser[1:0] == KIND_TRAILER))
    else $error("end of stream outside final trailer byte");

  a_zlib_hdr_not_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser[1:0] == KIND_ZLIB_HDR) |-> !m_axis_tlast)
    else $error("zlib header marked as last of run");

endmodule

bind zlib_stored_block_framer zsbf_checker u_zsbf_checker (.*);
